### src/rpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpba_pkg
// Shared types and constants for the RTP port block allocator.
// ----------------------------------------------------------------------------
package rpba_pkg;

  localparam int SERVERS = 4;
  localparam int CALLS   = 32;
  localparam int SW      = $clog2(SERVERS);
  localparam int CW      = $clog2(CALLS);
  localparam int FQ      = 2;

  localparam logic [16:0] BLOCK = 17'd4;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_REMOVE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_MISSING = 3'd2,
    ST_NOCAP   = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] server_id;
    logic [31:0] call_tag;
    logic [15:0] range_low;
    logic [15:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] chosen_server;
    logic [15:0] media_port;
    logic [16:0] control_port;
    logic [16:0] client_port;
    logic [16:0] inner_port;
    logic        stopped_valid;
    logic [31:0] stopped_call;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ADD,
    BK_ASCAN,
    BK_ABEST,
    BK_AFREE,
    BK_AOUT,
    BK_RSCAN,
    BK_RPUSH,
    BK_RMSCAN,
    BK_RMDONE,
    BK_EMIT
  } bk_state_t;

endpackage

### src/rtp_port_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_port_block_allocator
// Media server table with four-port block allocation per call.
// ----------------------------------------------------------------------------
// Usage: present an operation on in_valid/in_data (add server, allocate,
// release call, remove server); results come back on out_valid/out_data,
// one per operation, or one per held call on a remove, the final one with
// last set. A two-entry queue takes transactions while the engine works.
// Allocate time is set by the one-entry-a-cycle call table scan and the
// serial ratio compare; release scans the call table the same way; remove
// scans one call entry per cycle while no result is waiting to be taken.
// One operation is processed at a time.
// Reset clears the server table and all call valid bits at once; no clearing
// pass is needed. When the receiver stalls, the result register holds and
// the engine waits; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module rtp_port_block_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rpba_pkg::out_item_t out_data
);
  import rpba_pkg::*;

  logic     q_valid, q_ready;
  in_item_t q_data;

  rpba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (in_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  rpba_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op_data   (q_data),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_data  (out_data)
  );

endmodule

### src/rpba_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpba_queue
// Short FIFO between the front end and the operation engine.
// ----------------------------------------------------------------------------
module rpba_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  rpba_pkg::in_item_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output rpba_pkg::in_item_t rd_data
);
  import rpba_pkg::*;

  in_item_t   mem_r [FQ];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'(FQ));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= wp_r + 1'b1;
      if (rd_valid && rd_ready) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

### src/rpba_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpba_engine
// Back end: carries out one operation at a time against the server and call
// tables, scanning one entry a cycle when not held, and drives a result register.
// ----------------------------------------------------------------------------
module rpba_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  output logic                op_ready,
  input  rpba_pkg::in_item_t  op_data,
  output logic                res_valid,
  input  logic                res_ready,
  output rpba_pkg::out_item_t res_data
);
  import rpba_pkg::*;

  localparam int FW = SW + CW;

  bk_state_t   state_r, state_nxt;

  logic        srv_valid_r  [SERVERS];
  logic [31:0] srv_route_r  [SERVERS];
  logic [16:0] srv_total_r  [SERVERS];
  logic [16:0] srv_used_r   [SERVERS];
  logic [16:0] srv_next_r   [SERVERS];
  logic [CW-1:0] free_head_r [SERVERS];
  logic [CW:0]   free_cnt_r  [SERVERS];

  logic        call_valid_r [CALLS];
  logic [31:0] call_id_r    [CALLS];
  logic [SW-1:0] call_srv_r [CALLS];
  logic [15:0] call_port_r  [CALLS];

  logic [15:0] free_mem [SERVERS*CALLS];
  logic [15:0] free_rd_r;

  in_item_t    cur_r;
  logic [CW:0] ci_r;        // call scan index
  logic [SW:0] si_r;        // server scan index
  logic [CW-1:0] slot_r;    // chosen call entry
  logic        found_r;
  logic [SW-1:0] best_r;
  logic        have_best_r;
  logic        any_r;
  logic [CW-1:0] hit_r;
  logic        hit_valid_r;
  logic [33:0] prod_a_r, prod_b_r;
  logic        cmp_pend_r;
  logic [SW-1:0] cand_r;

  out_item_t   res_r;
  logic        res_valid_r;

  // front end scans of small server table (SERVERS entries, parallel compare)
  logic          match_any;
  logic [SW-1:0] match_idx;
  logic          free_any;
  logic [SW-1:0] free_idx;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int s = SERVERS - 1; s >= 0; s--) begin
      if (srv_valid_r[s] && srv_route_r[s] == cur_r.server_id) begin
        match_any = 1'b1;
        match_idx = SW'(s);
      end
      if (!srv_valid_r[s]) begin
        free_any = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  logic          ci_end;
  logic [CW-1:0] ci;
  logic [SW-1:0] si;
  logic          si_end;
  logic          elig;
  assign ci_end = (ci_r == (CW+1)'(CALLS));
  assign ci     = ci_r[CW-1:0];
  assign si_end = (si_r == (SW+1)'(SERVERS));
  assign si     = si_r[SW-1:0];
  assign elig   = srv_valid_r[si] && (srv_total_r[si] != 17'd0) &&
                  (srv_used_r[si] <= srv_total_r[si]) &&
                  ((srv_total_r[si] - srv_used_r[si]) >= BLOCK);

  assign op_ready  = (state_r == BK_IDLE);
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (op_valid) begin
        case (opcode_t'(op_data.opcode))
          OP_ADD:     state_nxt = BK_ADD;
          OP_ALLOC:   state_nxt = BK_ASCAN;
          OP_RELEASE: state_nxt = BK_RSCAN;
          OP_REMOVE:  state_nxt = BK_RMSCAN;
          default:    state_nxt = BK_IDLE;
        endcase
      end
      BK_ADD:    state_nxt = BK_EMIT;
      BK_ASCAN:  if (found_r || ci_end) state_nxt = found_r ? BK_ABEST : BK_EMIT;
      BK_ABEST:  if (si_end && !cmp_pend_r) state_nxt = have_best_r ? BK_AFREE : BK_EMIT;
      BK_AFREE:  state_nxt = BK_AOUT;
      BK_AOUT:   state_nxt = BK_EMIT;
      BK_RSCAN:  if (hit_valid_r || ci_end) state_nxt = hit_valid_r ? BK_RPUSH : BK_EMIT;
      BK_RPUSH:  state_nxt = BK_EMIT;
      BK_RMSCAN: if (ci_end && !res_valid_r) state_nxt = BK_RMDONE;
      BK_RMDONE: state_nxt = BK_EMIT;
      BK_EMIT:   if (!res_valid_r) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  function automatic out_item_t mk(input logic [2:0] st, input logic [31:0] rt,
                                   input logic hp, input logic [15:0] p,
                                   input logic sv, input logic [31:0] sc,
                                   input logic lst);
    out_item_t o;
    o.status        = st;
    o.chosen_server = rt;
    o.media_port    = hp ? p : 16'd0;
    o.control_port  = hp ? ({1'b0, p} + 17'd1) : 17'd0;
    o.client_port   = hp ? ({1'b0, p} + 17'd2) : 17'd0;
    o.inner_port    = hp ? ({1'b0, p} + 17'd3) : 17'd0;
    o.stopped_valid = sv;
    o.stopped_call  = sc;
    o.last          = lst;
    return o;
  endfunction

  // pending result, parked until the output register is free
  out_item_t pend_r;

  logic [FW-1:0] faddr;
  assign faddr = {best_r, free_head_r[best_r]};

  always_ff @(posedge clk) begin
    // free list memory: one write, one registered read
    if (state_r == BK_RPUSH && free_cnt_r[call_srv_r[hit_r]] < (CW+1)'(CALLS)) begin
      free_mem[{call_srv_r[hit_r], CW'(free_head_r[call_srv_r[hit_r]] +
               free_cnt_r[call_srv_r[hit_r]][CW-1:0])}] <= call_port_r[hit_r];
    end
    free_rd_r <= free_mem[faddr];

    if (state_r == BK_IDLE) cur_r <= op_data;

    if (!rst_n) begin
      state_r     <= BK_IDLE;
      res_valid_r <= 1'b0;
      for (int s = 0; s < SERVERS; s++) begin
        srv_valid_r[s] <= 1'b0;
        srv_route_r[s] <= '0;
        srv_total_r[s] <= '0;
        srv_used_r[s]  <= '0;
        srv_next_r[s]  <= '0;
        free_head_r[s] <= '0;
        free_cnt_r[s]  <= '0;
      end
      for (int c = 0; c < CALLS; c++) call_valid_r[c] <= 1'b0;
      ci_r <= '0;
      si_r <= '0;
      found_r <= 1'b0;
      hit_valid_r <= 1'b0;
      have_best_r <= 1'b0;
      cmp_pend_r <= 1'b0;
      any_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;

      case (state_r)
        BK_IDLE: begin
          ci_r <= '0;
          si_r <= '0;
          found_r <= 1'b0;
          hit_valid_r <= 1'b0;
          have_best_r <= 1'b0;
          cmp_pend_r <= 1'b0;
          any_r <= 1'b0;
        end
        BK_ADD: begin
          if (match_any) begin
            pend_r <= mk(ST_EXISTS, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
          end else if (!free_any) begin
            pend_r <= mk(ST_FULL, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
          end else begin
            srv_valid_r[free_idx] <= 1'b1;
            srv_route_r[free_idx] <= cur_r.server_id;
            srv_total_r[free_idx] <= (cur_r.range_high >= cur_r.range_low) ?
              ({1'b0, cur_r.range_high} - {1'b0, cur_r.range_low} + 17'd1) : 17'd0;
            srv_used_r[free_idx]  <= '0;
            srv_next_r[free_idx]  <= {1'b0, cur_r.range_low};
            free_head_r[free_idx] <= '0;
            free_cnt_r[free_idx]  <= '0;
            pend_r <= mk(ST_OK, cur_r.server_id, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
          end
        end
        BK_ASCAN: begin
          if (!found_r && !ci_end) begin
            if (!call_valid_r[ci]) begin
              found_r <= 1'b1;
              slot_r  <= ci;
            end else begin
              ci_r <= ci_r + 1'b1;
            end
          end
          if (!found_r && ci_end)
            pend_r <= mk(ST_FULL, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
        end
        BK_ABEST: begin
          // each eligible candidate after the first: multiply, then compare
          if (cmp_pend_r) begin
            cmp_pend_r <= 1'b0;
            if (prod_a_r < prod_b_r) best_r <= cand_r;
          end else if (!si_end) begin
            si_r <= si_r + 1'b1;
            if (elig) begin
              if (!have_best_r) begin
                have_best_r <= 1'b1;
                best_r <= si;
              end else begin
                prod_a_r <= srv_used_r[si] * srv_total_r[best_r];
                prod_b_r <= srv_used_r[best_r] * srv_total_r[si];
                cand_r <= si;
                cmp_pend_r <= 1'b1;
              end
            end
          end else if (!have_best_r) begin
            pend_r <= mk(ST_NOCAP, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
          end
        end
        BK_AFREE: ; // free list read in flight
        BK_AOUT: begin
          logic [15:0] port;
          port = (free_cnt_r[best_r] != '0) ? free_rd_r : srv_next_r[best_r][15:0];
          srv_used_r[best_r] <= srv_used_r[best_r] + BLOCK;
          if (free_cnt_r[best_r] != '0) begin
            free_head_r[best_r] <= free_head_r[best_r] + 1'b1;
            free_cnt_r[best_r]  <= free_cnt_r[best_r] - 1'b1;
          end else begin
            srv_next_r[best_r] <= srv_next_r[best_r] + BLOCK;
          end
          call_valid_r[slot_r] <= 1'b1;
          call_id_r[slot_r]    <= cur_r.call_tag;
          call_srv_r[slot_r]   <= best_r;
          call_port_r[slot_r]  <= port;
          pend_r <= mk(ST_OK, srv_route_r[best_r], 1'b1, port, 1'b0, 32'd0, 1'b1);
        end
        BK_RSCAN: begin
          if (!hit_valid_r && !ci_end) begin
            if (call_valid_r[ci] && call_id_r[ci] == cur_r.call_tag) begin
              hit_valid_r <= 1'b1;
              hit_r <= ci;
            end else begin
              ci_r <= ci_r + 1'b1;
            end
          end
          if (!hit_valid_r && ci_end)
            pend_r <= mk(ST_UNKNOWN, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
        end
        BK_RPUSH: begin
          logic [SW-1:0] sv;
          sv = call_srv_r[hit_r];
          call_valid_r[hit_r] <= 1'b0;
          srv_used_r[sv] <= (srv_used_r[sv] >= BLOCK) ? srv_used_r[sv] - BLOCK : 17'd0;
          if (free_cnt_r[sv] < (CW+1)'(CALLS)) free_cnt_r[sv] <= free_cnt_r[sv] + 1'b1;
          pend_r <= mk(ST_OK, srv_route_r[sv], 1'b1, call_port_r[hit_r], 1'b0, 32'd0,
                       1'b1);
        end
        BK_RMSCAN: begin
          if (!match_any) begin
            ci_r <= (CW+1)'(CALLS);
            pend_r <= mk(ST_MISSING, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
            any_r <= 1'b1;
          end else if (!ci_end && !res_valid_r) begin
            // a held call is emitted once the next one is known: hold one in pend_r
            ci_r <= ci_r + 1'b1;
            if (call_valid_r[ci] && call_srv_r[ci] == match_idx) begin
              call_valid_r[ci] <= 1'b0;
              if (any_r) begin
                res_r <= pend_r;
                res_valid_r <= 1'b1;
              end
              pend_r <= mk(ST_OK, cur_r.server_id, 1'b0, 16'd0, 1'b1, call_id_r[ci], 1'b0);
              any_r <= 1'b1;
            end
          end
        end
        BK_RMDONE: begin
          if (!any_r) begin
            pend_r <= mk(ST_OK, cur_r.server_id, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
          end else begin
            pend_r.last <= 1'b1;
          end
          if (match_any) begin
            srv_valid_r[match_idx] <= 1'b0;
            srv_route_r[match_idx] <= '0;
            srv_total_r[match_idx] <= '0;
            srv_used_r[match_idx]  <= '0;
            srv_next_r[match_idx]  <= '0;
            free_head_r[match_idx] <= '0;
            free_cnt_r[match_idx]  <= '0;
          end
        end
        BK_EMIT: begin
          if (!res_valid_r) begin
            res_r <= pend_r;
            res_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### sim/rpba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpba_checker
// Watches both channels of the port block allocator, predicts the results of
// every accepted operation from its own copy of the server and call tables,
// and compares each result transaction in full, in order.
// ----------------------------------------------------------------------------
module rpba_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rpba_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rpba_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import rpba_pkg::*;

  localparam int EXP_DEPTH = 1024;

  logic        srv_on    [SERVERS];
  logic [31:0] srv_id    [SERVERS];
  logic [16:0] srv_size  [SERVERS];
  logic [16:0] srv_taken [SERVERS];
  logic [16:0] srv_next  [SERVERS];
  logic [15:0] fifo      [SERVERS][CALLS];
  int          fifo_head [SERVERS];
  int          fifo_cnt  [SERVERS];
  logic        call_on   [CALLS];
  logic [31:0] call_tag  [CALLS];
  int          call_srv  [CALLS];
  logic [15:0] call_blk  [CALLS];

  // expected results, ring buffer
  out_item_t exp_buf [EXP_DEPTH];
  int        exp_wr;
  int        exp_rd;

  assign pending = exp_wr - exp_rd;

  function automatic out_item_t mk(status_t st, logic [31:0] route, logic has_blk,
                                   logic [15:0] blk, logic sv, logic [31:0] sc,
                                   logic lst);
    out_item_t r;
    r.status        = st;
    r.chosen_server = route;
    r.media_port    = has_blk ? blk : 16'd0;
    r.control_port  = has_blk ? {1'b0, blk} + 17'd1 : 17'd0;
    r.client_port   = has_blk ? {1'b0, blk} + 17'd2 : 17'd0;
    r.inner_port    = has_blk ? {1'b0, blk} + 17'd3 : 17'd0;
    r.stopped_valid = sv;
    r.stopped_call  = sc;
    r.last          = lst;
    return r;
  endfunction

  function automatic out_item_t err_item(status_t st);
    return mk(st, 32'd0, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1);
  endfunction

  function automatic void expect_result(out_item_t r);
    exp_buf[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic int lookup_server(logic [31:0] route);
    for (int s = 0; s < SERVERS; s++)
      if (srv_on[s] && srv_id[s] == route) return s;
    return -1;
  endfunction

  task automatic predict_operation(in_item_t it);
    int slot, best, c, n;
    logic [15:0] blk;
    case (opcode_t'(it.opcode))
      OP_ADD: begin
        slot = -1;
        for (int s = SERVERS - 1; s >= 0; s--) if (!srv_on[s]) slot = s;
        if (lookup_server(it.server_id) >= 0)
          expect_result(err_item(ST_EXISTS));
        else if (slot < 0)
          expect_result(err_item(ST_FULL));
        else begin
          srv_on[slot]    = 1;
          srv_id[slot]    = it.server_id;
          srv_size[slot]  = (it.range_high >= it.range_low) ?
                            {1'b0, it.range_high} - {1'b0, it.range_low} + 17'd1 : 17'd0;
          srv_taken[slot] = 0;
          srv_next[slot]  = {1'b0, it.range_low};
          fifo_head[slot] = 0;
          fifo_cnt[slot]  = 0;
          expect_result(mk(ST_OK, it.server_id, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1));
        end
      end
      OP_ALLOC: begin
        slot = -1;
        for (c = CALLS - 1; c >= 0; c--) if (!call_on[c]) slot = c;
        if (slot < 0) begin
          expect_result(err_item(ST_FULL));
          return;
        end
        best = -1;
        for (int s = 0; s < SERVERS; s++) begin
          if (!srv_on[s] || srv_size[s] == 0) continue;
          if (srv_taken[s] > srv_size[s] || srv_size[s] - srv_taken[s] < BLOCK) continue;
          if (best < 0 || 64'(srv_taken[s]) * srv_size[best] <
                          64'(srv_taken[best]) * srv_size[s])
            best = s;
        end
        if (best < 0) begin
          expect_result(err_item(ST_NOCAP));
          return;
        end
        srv_taken[best] += BLOCK;
        if (fifo_cnt[best] > 0) begin
          blk = fifo[best][fifo_head[best]];
          fifo_head[best] = (fifo_head[best] + 1) % CALLS;
          fifo_cnt[best]--;
        end else begin
          blk = srv_next[best][15:0];
          srv_next[best] = srv_next[best] + BLOCK;
        end
        call_on[slot]  = 1;
        call_tag[slot] = it.call_tag;
        call_srv[slot] = best;
        call_blk[slot] = blk;
        expect_result(mk(ST_OK, srv_id[best], 1'b1, blk, 1'b0, 32'd0, 1'b1));
      end
      OP_RELEASE: begin
        slot = -1;
        for (c = CALLS - 1; c >= 0; c--)
          if (call_on[c] && call_tag[c] == it.call_tag) slot = c;
        if (slot < 0) begin
          expect_result(err_item(ST_UNKNOWN));
          return;
        end
        best = call_srv[slot];
        call_on[slot] = 0;
        srv_taken[best] = (srv_taken[best] >= BLOCK) ? srv_taken[best] - BLOCK : 17'd0;
        if (fifo_cnt[best] < CALLS) begin
          fifo[best][(fifo_head[best] + fifo_cnt[best]) % CALLS] = call_blk[slot];
          fifo_cnt[best]++;
        end
        expect_result(mk(ST_OK, srv_id[best], 1'b1, call_blk[slot], 1'b0, 32'd0, 1'b1));
      end
      OP_REMOVE: begin
        slot = lookup_server(it.server_id);
        if (slot < 0) begin
          expect_result(err_item(ST_MISSING));
          return;
        end
        n = 0;
        for (c = 0; c < CALLS; c++)
          if (call_on[c] && call_srv[c] == slot) begin
            expect_result(mk(ST_OK, it.server_id, 1'b0, 16'd0, 1'b1, call_tag[c], 1'b0));
            call_on[c] = 0;
            n++;
          end
        if (n == 0)
          expect_result(mk(ST_OK, it.server_id, 1'b0, 16'd0, 1'b0, 32'd0, 1'b1));
        else
          exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
        srv_on[slot] = 0; srv_id[slot] = 0; srv_size[slot] = 0;
        srv_taken[slot] = 0; srv_next[slot] = 0;
        fifo_head[slot] = 0; fifo_cnt[slot] = 0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int s = 0; s < SERVERS; s++) begin
        srv_on[s] = 0; srv_id[s] = 0; srv_size[s] = 0; srv_taken[s] = 0;
        srv_next[s] = 0; fifo_head[s] = 0; fifo_cnt[s] = 0;
      end
      for (int c = 0; c < CALLS; c++) call_on[c] = 0;
      exp_wr = 0;
      exp_rd = 0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) predict_operation(in_data);
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction %p", out_data);
        end else begin
          want = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
  end

endmodule

### sim/rtp_port_block_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_port_block_allocator_test
// Drives server add/remove and call allocate/release traffic with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rtp_port_block_allocator_test;
  import rpba_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  // small pools so that adds, releases and removes hit existing entries
  logic [31:0] route_pool[6] = '{32'h1, 32'hFFFF_FFFF, 32'h0, 32'hA5A5_5A5A,
                                 32'h8000_0000, 32'h7FFF_FFFE};
  logic [31:0] tag_pool[512];
  int          tag_cnt;

  rtp_port_block_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rpba_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // valid drops only when a gap follows, so back-to-back transactions keep it high
  task automatic send_op(opcode_t op, logic [31:0] sid, logic [31:0] tag,
                         logic [15:0] lo, logic [15:0] hi);
    in_item_t it;
    int g;
    it.opcode = op; it.server_id = sid; it.call_tag = tag;
    it.range_low = lo; it.range_high = hi;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_op();
    int k;
    logic [15:0] lo;
    logic [31:0] tag;
    k = $urandom_range(0, 99);
    if (k < 12) begin
      lo = 16'($urandom);
      if ($urandom_range(0, 9) == 0)
        send_op(OP_ADD, $urandom, $urandom, 16'($urandom), 16'($urandom));
      else send_op(OP_ADD, route_pool[$urandom_range(0, 5)], $urandom, lo,
                   lo + 16'($urandom_range(0, 200)));
    end else if (k < 55) begin
      tag = ($urandom_range(0, 3) == 0 && tag_cnt > 0) ?
            tag_pool[$urandom_range(0, tag_cnt - 1)] : $urandom;
      if (tag_cnt < 512) begin
        tag_pool[tag_cnt] = tag;
        tag_cnt++;
      end
      send_op(OP_ALLOC, $urandom, tag, 16'($urandom), 16'($urandom));
    end else if (k < 92) begin
      tag = (tag_cnt > 0 && $urandom_range(0, 7) != 0) ?
            tag_pool[$urandom_range(0, tag_cnt - 1)] : $urandom;
      send_op(OP_RELEASE, $urandom, tag, 16'($urandom), 16'($urandom));
    end else begin
      send_op(OP_REMOVE, ($urandom_range(0, 9) == 0) ? $urandom :
              route_pool[$urandom_range(0, 5)], $urandom, 16'($urandom), 16'($urandom));
    end
  endtask

  // receiver back-pressure
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    int guard;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    tag_cnt   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: error paths on an empty table, extremes, full tables
    send_op(OP_ALLOC, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0);
    send_op(OP_RELEASE, 32'h0, 32'h1234, 16'h0, 16'h0);
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0);
    send_op(OP_ADD, 32'h0, 32'h0, 16'hFFFF, 16'h0);            // inverted range
    send_op(OP_ALLOC, 32'h0, 32'h1, 16'h0, 16'h0);
    send_op(OP_ADD, 32'h0, 32'h0, 16'h0, 16'hFFFF);            // route exists
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'h0, 16'hFFF8, 16'hFFFF); // top of range
    send_op(OP_ADD, 32'h5, 32'h0, 16'h0, 16'h7);
    send_op(OP_ADD, 32'h6, 32'h0, 16'h0, 16'hFFFF);
    send_op(OP_ADD, 32'h7, 32'h0, 16'h0, 16'h0);               // table full
    for (int i = 0; i < 7; i++) send_op(OP_ALLOC, 32'h0, 32'h100 + i, 16'h0, 16'h0);
    send_op(OP_ALLOC, 32'h0, 32'h100, 16'h0, 16'h0);           // duplicate tag
    send_op(OP_RELEASE, 32'h0, 32'h100, 16'h0, 16'h0);
    send_op(OP_ALLOC, 32'h0, 32'h200, 16'h0, 16'h0);           // from free list
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0);
    send_op(OP_REMOVE, 32'h0, 32'h0, 16'h0, 16'h0);
    for (int i = 0; i < 30; i++) send_op(OP_ALLOC, 32'h0, i, 16'h0, 16'h0);  // call table full
    send_op(OP_REMOVE, 32'h6, 32'h0, 16'h0, 16'h0);            // many stopped calls
    send_op(OP_REMOVE, 32'h5, 32'h0, 16'h0, 16'h0);

    for (int i = 0; i < 350; i++) random_op();
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
